@@ hdl/go_to_goal_steering_assert.svh @@
// Assertion macros shared by the steering checker.
`ifndef GO_TO_GOAL_STEERING_ASSERT_SVH
`define GO_TO_GOAL_STEERING_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define GTG_ASSERT_SAME(lbl, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("steering check failed");

// Consequence must hold in the cycle after the antecedent.
`define GTG_ASSERT_NEXT(lbl, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("steering check failed");

`endif

@@ hdl/gtg_pkg.sv @@
package gtg_pkg;

    // CORDIC datapath widths: operands reach 2^48 before gain growth.
    localparam int CW = 52;
    localparam int ZW = 34;
    localparam int EW = 35;
    localparam int MW = CW - 1;
    localparam int ACC_W = 67;

    localparam logic signed [ZW-1:0] ANG_HALF_PI = 34'sd843314857;
    localparam logic signed [EW-1:0] ANG_PI = 35'sd1686629713;
    localparam logic signed [EW-1:0] ANG_TWO_PI = 35'sd3373259426;
    localparam logic [29:0] INV_GAIN = 30'd652032874;

    // Request types.
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_STOP = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOST = 2'd1;
    localparam logic [1:0] ST_REACHED = 2'd2;
    localparam logic [1:0] ST_STEER = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] REG_TARGET_X = 3'd0;
    localparam logic [2:0] REG_TARGET_Z = 3'd1;
    localparam logic [2:0] REG_REACH = 3'd2;
    localparam logic [2:0] REG_CRUISE = 3'd3;
    localparam logic [2:0] REG_GAIN = 3'd4;
    localparam logic [2:0] REG_MIN = 3'd5;

    // Result of one CORDIC vectoring run.
    typedef struct packed {
        logic done;
        logic signed [ZW-1:0] angle;
        logic signed [CW-1:0] x;
    } cordic_res_t;

    // Arctangent of 2^-i in Q29 radians.
    function automatic logic signed [ZW-1:0] atan_q29(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        begin
            case (idx)
                5'd0: v = 34'sd421657428;
                5'd1: v = 34'sd248918915;
                5'd2: v = 34'sd131521918;
                5'd3: v = 34'sd66762579;
                5'd4: v = 34'sd33510843;
                5'd5: v = 34'sd16771758;
                5'd6: v = 34'sd8387925;
                5'd7: v = 34'sd4194219;
                5'd8: v = 34'sd2097141;
                5'd9: v = 34'sd1048575;
                5'd10: v = 34'sd524288;
                5'd11: v = 34'sd262144;
                5'd12: v = 34'sd131072;
                5'd13: v = 34'sd65536;
                5'd14: v = 34'sd32768;
                5'd15: v = 34'sd16384;
                5'd16: v = 34'sd8192;
                5'd17: v = 34'sd4096;
                5'd18: v = 34'sd2048;
                5'd19: v = 34'sd1024;
                5'd20: v = 34'sd512;
                5'd21: v = 34'sd256;
                5'd22: v = 34'sd128;
                5'd23: v = 34'sd64;
                5'd24: v = 34'sd32;
                5'd25: v = 34'sd16;
                5'd26: v = 34'sd8;
                5'd27: v = 34'sd4;
                5'd28: v = 34'sd2;
                5'd29: v = 34'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ hdl/gtg_cordic.sv @@
module gtg_cordic
    import gtg_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [CW-1:0] x_in,
    output cordic_res_t          res
);

    localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;

    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [IW-1:0] i_reg, i_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic signed [CW-1:0] xs, ys;

    // One micro-rotation per cycle; quadrant fold on start.
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        if (start)
        begin
            busy_next = 1'b1;
            i_next = '0;
            if (x_in[CW-1] && !y_in[CW-1])
            begin
                x_next = y_in;
                y_next = -x_in;
                z_next = ANG_HALF_PI;
            end
            else if (x_in[CW-1])
            begin
                x_next = -y_in;
                y_next = x_in;
                z_next = -ANG_HALF_PI;
            end
            else
            begin
                x_next = x_in;
                y_next = y_in;
                z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (!y_reg[CW-1])
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_q29(5'(i_reg));
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_q29(5'(i_reg));
            end
            i_next = i_reg + 1'b1;
            if (i_reg == IW'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            i_reg <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign res.done = done_reg;
    assign res.angle = z_reg;
    assign res.x = x_reg;

endmodule

@@ hdl/go_to_goal_steering.sv @@
// Go-to-goal steering controller. Start and stop requests only set or clear
// the driving flag and give no result. A pose tick while not driving, or
// with an invalid pose, gives its result without a CORDIC run. A steering
// tick uses the shared CORDIC unit twice (heading, then bearing and
// magnitude), then the distance multiply, the error wrap and the wheel
// speed step; CORDIC_STEPS defaults to 16. in_stall is high while a tick
// is being worked.
module go_to_goal_steering
    import gtg_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic               pose_valid,
    input  logic signed [31:0] trans_x,
    input  logic signed [31:0] trans_z,
    input  logic signed [15:0] rot_zx,
    input  logic signed [15:0] rot_zz,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic               speed_valid,
    output logic signed [15:0] left_speed,
    output logic signed [15:0] right_speed,
    output logic [31:0]        distance_out,
    output logic signed [15:0] heading_error
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_HEAD  = 8'b0000_0010,
        S_BEAR  = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_DIST  = 8'b0001_0000,
        S_SLOW  = 8'b0010_0000,
        S_STEER = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    localparam logic [1:0] MUL_LO = 2'd0;
    localparam logic [1:0] MUL_MID = 2'd1;
    localparam logic [1:0] MUL_HI = 2'd2;

    state_t state_reg, state_next;
    logic driving_reg, driving_next;

    logic signed [31:0] tgt_x_reg, tgt_z_reg;
    logic [30:0] reach_reg;
    logic [14:0] cruise_reg, gain_reg;
    logic signed [15:0] min_reg;

    logic signed [32:0] dx_reg, dx_next, dz_reg, dz_next;
    logic signed [ZW-1:0] head_reg, head_next, bear_reg, bear_next;
    logic [MW-1:0] mag_reg, mag_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [1:0] mcnt_reg, mcnt_next;
    logic [31:0] dist_reg, dist_next;
    logic signed [15:0] e13_reg, e13_next;
    logic [29:0] sprod_reg, sprod_next;

    logic [1:0] rs_status_reg, rs_status_next;
    logic rs_sv_reg, rs_sv_next;
    logic signed [15:0] rs_left_reg, rs_left_next, rs_right_reg, rs_right_next;
    logic [31:0] rs_dist_reg, rs_dist_next;
    logic signed [15:0] rs_err_reg, rs_err_next;

    logic ov_reg, ov_next;
    logic [1:0] o_status_reg;
    logic o_sv_reg;
    logic signed [15:0] o_left_reg, o_right_reg, o_err_reg;
    logic [31:0] o_dist_reg;

    logic cord_start;
    logic signed [CW-1:0] cord_y, cord_x;
    cordic_res_t cord;

    logic accept;
    logic load_out;
    logic [34:0] hi;
    logic [17:0] mop;
    logic [47:0] mprod;
    logic [ACC_W-1:0] mterm;
    logic signed [EW-1:0] err_raw, err_wrap, err_rnd;
    logic [36:0] dist_wide;
    logic [14:0] e_abs;
    logic [17:0] slow;
    logic signed [19:0] inner;

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign load_out = (state_reg == S_DONE) && (!ov_reg || !out_stall);

    // Operands for the shared CORDIC unit: rotation on the first run, offset next.
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            cord_y = {{(CW-32){rot_zx[15]}}, rot_zx, 16'd0};
            cord_x = {{(CW-32){rot_zz[15]}}, rot_zz, 16'd0};
        end
        else
        begin
            cord_y = {{(CW-49){dx_reg[32]}}, dx_reg, 16'd0};
            cord_x = {{(CW-49){dz_reg[32]}}, dz_reg, 16'd0};
        end
    end

    gtg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .y_in  (cord_y),
        .x_in  (cord_x),
        .res   (cord)
    );

    // Distance multiply: the magnitude is scaled in three partial products.
    assign hi = mag_reg[MW-1:16];
    always_comb
    begin
        case (mcnt_reg)
            MUL_LO: mop = {2'b00, mag_reg[15:0]};
            MUL_MID: mop = {1'b0, hi[16:0]};
            default: mop = hi[34:17];
        endcase
        mprod = 48'(mop) * 48'(INV_GAIN);
        case (mcnt_reg)
            MUL_LO: mterm = ACC_W'(mprod >> 16);
            MUL_MID: mterm = ACC_W'(mprod);
            default: mterm = ACC_W'(mprod) << 17;
        endcase
    end

    // Heading error wrap and rounding to Q3.13.
    always_comb
    begin
        err_raw = EW'(bear_reg) - EW'(head_reg);
        err_wrap = err_raw;
        if (err_raw < -ANG_PI)
        begin
            err_wrap = err_raw + ANG_TWO_PI;
        end
        else if (err_raw > ANG_PI)
        begin
            err_wrap = err_raw - ANG_TWO_PI;
        end
        err_rnd = (err_wrap + EW'(32768)) >>> 16;
        dist_wide = acc_reg[ACC_W-1:30];
    end

    // Wheel slowdown and inner wheel clamp.
    always_comb
    begin
        e_abs = e13_reg[15] ? 15'(-e13_reg) : 15'(e13_reg);
        slow = 18'((31'(sprod_reg) + 31'd4096) >> 13);
        inner = 20'(signed'({5'd0, cruise_reg})) - 20'(signed'({2'b00, slow}));
        if (inner < 20'(min_reg))
        begin
            inner = 20'(min_reg);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        driving_next = driving_reg;
        dx_next = dx_reg;
        dz_next = dz_reg;
        head_next = head_reg;
        bear_next = bear_reg;
        mag_next = mag_reg;
        acc_next = acc_reg;
        mcnt_next = mcnt_reg;
        dist_next = dist_reg;
        e13_next = e13_reg;
        sprod_next = sprod_reg;
        rs_status_next = rs_status_reg;
        rs_sv_next = rs_sv_reg;
        rs_left_next = rs_left_reg;
        rs_right_next = rs_right_reg;
        rs_dist_next = rs_dist_reg;
        rs_err_next = rs_err_reg;
        cord_start = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_START: driving_next = 1'b1;
                        REQ_STOP: driving_next = 1'b0;
                        REQ_TICK:
                        begin
                            rs_status_next = ST_IDLE;
                            rs_sv_next = 1'b0;
                            rs_left_next = '0;
                            rs_right_next = '0;
                            rs_dist_next = '0;
                            rs_err_next = '0;
                            dx_next = 33'(tgt_x_reg) + 33'(trans_x);
                            dz_next = 33'(tgt_z_reg) + 33'(trans_z);
                            if (!driving_reg)
                            begin
                                rs_sv_next = 1'b1;
                                state_next = S_DONE;
                            end
                            else if (!pose_valid)
                            begin
                                driving_next = 1'b0;
                                rs_status_next = ST_LOST;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                cord_start = 1'b1;
                                state_next = S_HEAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_HEAD:
            begin
                if (cord.done)
                begin
                    head_next = cord.angle;
                    cord_start = 1'b1;
                    state_next = S_BEAR;
                end
            end
            S_BEAR:
            begin
                if (cord.done)
                begin
                    bear_next = cord.angle;
                    mag_next = cord.x[CW-1] ? '0 : cord.x[MW-1:0];
                    acc_next = '0;
                    mcnt_next = MUL_LO;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                acc_next = acc_reg + mterm;
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == MUL_HI)
                begin
                    state_next = S_DIST;
                end
            end
            S_DIST:
            begin
                dist_next = (dist_wide[36:32] != 5'd0) ? 32'hFFFF_FFFF : dist_wide[31:0];
                e13_next = 16'(err_rnd);
                state_next = S_SLOW;
            end
            S_SLOW:
            begin
                sprod_next = 30'(gain_reg) * 30'(e_abs);
                rs_dist_next = dist_reg;
                rs_err_next = e13_reg;
                if (dist_reg < {1'b0, reach_reg})
                begin
                    driving_next = 1'b0;
                    rs_status_next = ST_REACHED;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_STEER;
                end
            end
            S_STEER:
            begin
                rs_status_next = ST_STEER;
                rs_sv_next = 1'b1;
                if (e13_reg[15])
                begin
                    rs_left_next = signed'({1'b0, cruise_reg});
                    rs_right_next = 16'(inner);
                end
                else
                begin
                    rs_left_next = 16'(inner);
                    rs_right_next = signed'({1'b0, cruise_reg});
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output register handshake.
    always_comb
    begin
        ov_next = ov_reg;
        if (load_out)
        begin
            ov_next = 1'b1;
        end
        else if (!out_stall)
        begin
            ov_next = 1'b0;
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            driving_reg <= 1'b0;
            ov_reg <= 1'b0;
            mcnt_reg <= MUL_LO;
            tgt_x_reg <= '0;
            tgt_z_reg <= '0;
            reach_reg <= 31'd19661;
            cruise_reg <= 15'd6554;
            gain_reg <= 15'd12288;
            min_reg <= -16'sd3277;
        end
        else
        begin
            state_reg <= state_next;
            driving_reg <= driving_next;
            ov_reg <= ov_next;
            mcnt_reg <= mcnt_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_TARGET_X: tgt_x_reg <= cfg_data;
                    REG_TARGET_Z: tgt_z_reg <= cfg_data;
                    REG_REACH: reach_reg <= cfg_data[30:0];
                    REG_CRUISE: cruise_reg <= cfg_data[14:0];
                    REG_GAIN: gain_reg <= cfg_data[14:0];
                    REG_MIN: min_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        dx_reg <= dx_next;
        dz_reg <= dz_next;
        head_reg <= head_next;
        bear_reg <= bear_next;
        mag_reg <= mag_next;
        acc_reg <= acc_next;
        dist_reg <= dist_next;
        e13_reg <= e13_next;
        sprod_reg <= sprod_next;
        rs_status_reg <= rs_status_next;
        rs_sv_reg <= rs_sv_next;
        rs_left_reg <= rs_left_next;
        rs_right_reg <= rs_right_next;
        rs_dist_reg <= rs_dist_next;
        rs_err_reg <= rs_err_next;
        if (load_out)
        begin
            o_status_reg <= rs_status_reg;
            o_sv_reg <= rs_sv_reg;
            o_left_reg <= rs_left_reg;
            o_right_reg <= rs_right_reg;
            o_dist_reg <= rs_dist_reg;
            o_err_reg <= rs_err_reg;
        end
    end

    assign out_valid = ov_reg;
    assign status = o_status_reg;
    assign speed_valid = o_sv_reg;
    assign left_speed = o_left_reg;
    assign right_speed = o_right_reg;
    assign distance_out = o_dist_reg;
    assign heading_error = o_err_reg;

endmodule

@@ hdl/gtg_checker.sv @@
`include "go_to_goal_steering_assert.svh"

module gtg_checker
    import gtg_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [1:0]         req_type,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic               speed_valid,
    input logic signed [15:0] left_speed,
    input logic signed [15:0] right_speed
);

    // A pose tick keeps the block busy in the following cycle.
    `GTG_ASSERT_NEXT(a_tick_busy, rst_n, in_valid && !in_stall && req_type == REQ_TICK, in_stall)

    // A result that is held back stays offered.
    `GTG_ASSERT_NEXT(a_out_hold, rst_n, out_valid && out_stall, out_valid)

    // Steering results always carry a speed command.
    `GTG_ASSERT_SAME(a_steer_speed, rst_n, out_valid && status == ST_STEER, speed_valid)

    // Lost tracking gives no command and zero speeds.
    `GTG_ASSERT_SAME(a_lost_zero, rst_n, out_valid && status == ST_LOST,
        !speed_valid && left_speed == 16'sd0 && right_speed == 16'sd0)

endmodule

bind go_to_goal_steering gtg_checker u_gtg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .speed_valid (speed_valid),
    .left_speed  (left_speed),
    .right_speed (right_speed)
);

@@ verif/tb.sv @@
`default_nettype none

module tb
    import gtg_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 16;
    localparam longint Q29_PI = 64'sd1686629713;
    localparam longint Q29_HALF_PI = 64'sd843314857;
    localparam longint Q29_TWO_PI = 64'sd3373259426;
    localparam longint unsigned MAG_SCALE = 652032874;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;

    localparam longint ATAN_Q29 [0:STEPS-1] = '{
        421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
        8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
        32768, 16384
    };

    typedef struct {
        logic [1:0]         rq;
        logic               pv;
        logic signed [31:0] tx;
        logic signed [31:0] tz;
        logic signed [15:0] rx;
        logic signed [15:0] rz;
    } request_t;

    typedef struct {
        logic [1:0]         st;
        logic               sv;
        logic signed [15:0] ls;
        logic signed [15:0] rs;
        logic [31:0]        dst;
        logic signed [15:0] herr;
    } command_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         req_type = '0;
    logic               pose_valid = 1'b0;
    logic signed [31:0] trans_x = '0;
    logic signed [31:0] trans_z = '0;
    logic signed [15:0] rot_zx = '0;
    logic signed [15:0] rot_zz = '0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic               speed_valid;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [31:0]        distance_out;
    logic signed [15:0] heading_error;

    go_to_goal_steering dut (.*);

    // Shadow of the steering state and registers.
    longint goal_x, goal_z, reach_r, cruise, gain, floor_spd;
    bit     is_driving;

    request_t pending_q[$];
    command_t command_q[$];
    int       n_errors = 0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Vectoring rotation: returns the angle of (y, x) in Q29 radians.
    function automatic longint vector_angle(input longint y0, input longint x0,
                                            output longint gained_mag);
        longint x, y, z, t, xs, ys;
        x = x0;
        y = y0;
        z = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = Q29_HALF_PI;
            end
            else
            begin
                x = -y;
                y = t;
                z = -Q29_HALF_PI;
            end
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z += ATAN_Q29[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z -= ATAN_Q29[i];
            end
        end
        gained_mag = (x < 0) ? 0 : x;
        return z;
    endfunction

    // Steering law for one request; returns 1 when a command results.
    function automatic bit steer(input request_t r, output command_t c);
        longint dx, dz, hdg, brg, err, e13, mag, mag_err, slow, inner;
        longint unsigned umag, dist_u;
        c = '{default: '0};
        if (r.rq == REQ_START)
        begin
            is_driving = 1'b1;
            return 1'b0;
        end
        if (r.rq == REQ_STOP)
        begin
            is_driving = 1'b0;
            return 1'b0;
        end
        if (r.rq != REQ_TICK)
            return 1'b0;
        if (!is_driving)
        begin
            c.st = ST_IDLE;
            c.sv = 1'b1;
            return 1'b1;
        end
        if (!r.pv)
        begin
            is_driving = 1'b0;
            c.st = ST_LOST;
            return 1'b1;
        end
        dx = goal_x + longint'(r.tx);
        dz = goal_z + longint'(r.tz);
        hdg = vector_angle(longint'(r.rx) * 65536, longint'(r.rz) * 65536, mag);
        brg = vector_angle(dx * 65536, dz * 65536, mag);
        umag = mag;
        dist_u = ((umag >> 16) * MAG_SCALE + (((umag & 64'hFFFF) * MAG_SCALE) >> 16)) >> 30;
        if (dist_u > 64'hFFFF_FFFF)
            dist_u = 64'hFFFF_FFFF;
        err = brg - hdg;
        if (err < -Q29_PI)
            err += Q29_TWO_PI;
        if (err > Q29_PI)
            err -= Q29_TWO_PI;
        e13 = (err + 32768) >>> 16;
        c.dst = dist_u[31:0];
        c.herr = e13[15:0];
        if (longint'(dist_u) < reach_r)
        begin
            is_driving = 1'b0;
            c.st = ST_REACHED;
            return 1'b1;
        end
        mag_err = (e13 < 0) ? -e13 : e13;
        slow = (gain * mag_err + 4096) >>> 13;
        inner = cruise - slow;
        if (inner < floor_spd)
            inner = floor_spd;
        c.st = ST_STEER;
        c.sv = 1'b1;
        c.ls = (e13 < 0) ? cruise[15:0] : inner[15:0];
        c.rs = (e13 < 0) ? inner[15:0] : cruise[15:0];
        return 1'b1;
    endfunction

    // Request driver: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        command_t c;
        request_t r;
        logic     nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            nxt = in_valid;
            if (in_valid && !in_stall)
            begin
                if (steer(pending_q[0], c))
                    command_q.insert(command_q.size(), c);
                void'(pending_q.pop_front());
                nxt = 1'b0;
            end
            if (!nxt)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_q.size() > 0)
                begin
                    r = pending_q[0];
                    req_type <= r.rq;
                    pose_valid <= r.pv;
                    trans_x <= r.tx;
                    trans_z <= r.tz;
                    rot_zx <= r.rx;
                    rot_zz <= r.rz;
                    nxt = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 25);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
                    end
                end
            end
            in_valid <= nxt;
        end
    end

    // Result stall: changes mode every so often, including no stalls at all.
    int stall_mode = 0;
    int stall_run = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (stall_run == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_run = $urandom_range(5, 200);
            end
            else
                stall_run--;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= $urandom_range(0, 1);
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Command monitor: compares each accepted command with the oldest prediction.
    always @(posedge clk)
    begin
        command_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (command_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("%0t: unexpected command, status %0d", $realtime, status);
            end
            else
            begin
                e = command_q.pop_front();
                if (status !== e.st || speed_valid !== e.sv || left_speed !== e.ls
                    || right_speed !== e.rs || distance_out !== e.dst
                    || heading_error !== e.herr)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("%0t: mismatch exp st=%0d sv=%0d l=%0d r=%0d d=%0d e=%0d got st=%0d sv=%0d l=%0d r=%0d d=%0d e=%0d",
                                 $realtime, e.st, e.sv, e.ls, e.rs, e.dst, e.herr,
                                 status, speed_valid, left_speed, right_speed,
                                 distance_out, heading_error);
                end
            end
        end
    end

    // Fields are cut to their widths here.
    function automatic request_t mk(input int rq, input int pv,
                                    input longint tx, input longint tz,
                                    input int rx, input int rz);
        request_t r;
        r.rq = rq[1:0];
        r.pv = pv[0];
        r.tx = tx[31:0];
        r.tz = tz[31:0];
        r.rx = rx[15:0];
        r.rz = rz[15:0];
        return r;
    endfunction

    // Appends one request to the pending list.
    task automatic add_req(input request_t r);
        pending_q.insert(pending_q.size(), r);
    endtask

    function automatic request_t rand_tick();
        longint tx, tz;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            // Close to the target so that arrival comes up often.
            tx = -goal_x + $urandom_range(0, 80000) - 40000;
            tz = -goal_z + $urandom_range(0, 80000) - 40000;
        end
        else if (sel < 6)
        begin
            tx = -goal_x + $urandom_range(0, 2_000_000) - 1_000_000;
            tz = -goal_z + $urandom_range(0, 2_000_000) - 1_000_000;
        end
        else
        begin
            tx = $urandom;
            tz = $urandom;
        end
        return mk(REQ_TICK, $urandom_range(0, 15) != 0, tx, tz, $urandom, $urandom);
    endfunction

    // Mostly start followed by a run of ticks, the rest loose requests.
    task automatic queue_random(input int n);
        int k;
        while (n > 0)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                add_req(mk(REQ_START, $urandom, $urandom, $urandom,
                           $urandom, $urandom));
                k = $urandom_range(1, 8);
                repeat (k) add_req(rand_tick());
                n -= k + 1;
            end
            else
            begin
                add_req(mk($urandom_range(0, 3), $urandom, $urandom,
                           $urandom, $urandom, $urandom));
                n--;
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_q.size() > 0 || in_valid || command_q.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            REG_TARGET_X: goal_x = longint'(signed'(v));
            REG_TARGET_Z: goal_z = longint'(signed'(v));
            REG_REACH: reach_r = v[30:0];
            REG_CRUISE: cruise = v[14:0];
            REG_GAIN: gain = v[14:0];
            REG_MIN: floor_spd = longint'(signed'(v[15:0]));
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic write_all(input logic [31:0] tx, input logic [31:0] tz,
                             input logic [31:0] rr, input logic [31:0] cs,
                             input logic [31:0] tg, input logic [31:0] ms);
        @(posedge clk);
        reg_write(REG_TARGET_X, tx);
        reg_write(REG_TARGET_Z, tz);
        reg_write(REG_REACH, rr);
        reg_write(REG_CRUISE, cs);
        reg_write(REG_GAIN, tg);
        reg_write(REG_MIN, ms);
        reg_write(REG_SPARE_A, $urandom);
        reg_write(REG_SPARE_B, $urandom);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        goal_x = 0;
        goal_z = 0;
        reach_r = 19661;
        cruise = 6554;
        gain = 12288;
        floor_spd = -3277;
        is_driving = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle tick, lost pose, arrival, zero vectors, field extremes.
        write_all(32'sd100000, -32'sd50000, 19661, 6554, 12288, -32'sd3277);
        add_req(mk(REQ_TICK, 1, 0, 0, 0, 16384));
        add_req(mk(REQ_START, 0, 0, 0, 0, 0));
        add_req(mk(REQ_TICK, 0, 0, 0, 0, 0));
        add_req(mk(REQ_TICK, 1, 0, 0, 0, 16384));
        add_req(mk(REQ_START, 0, 0, 0, 0, 0));
        add_req(mk(REQ_TICK, 1, -100000, 50000, 0, 0));
        add_req(mk(REQ_START, 1, 0, 0, 0, 0));
        add_req(mk(REQ_TICK, 1, 0, 0, 0, 0));
        add_req(mk(REQ_TICK, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF));
        add_req(mk(REQ_TICK, 1, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000));
        add_req(mk(REQ_TICK, 1, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h8000));
        add_req(mk(REQ_TICK, 1, 0, -1_000_000, 16'h8000, 16'hC000));
        add_req(mk(REQ_TICK, 1, 0, 1_000_000, 16'h0000, 16'hC000));
        add_req(mk(REQ_UNUSED, 1, -1, -1, -1, -1));
        add_req(mk(REQ_TICK, 1, -100000, 60000, 16'h3000, 16'h2000));
        add_req(mk(REQ_STOP, 1, -1, -1, -1, -1));
        add_req(mk(REQ_TICK, 1, 5, 5, 5, 5));
        wait_idle();

        write_all($urandom, $urandom, $urandom_range(0, 200000), $urandom, $urandom, $urandom);
        queue_random(60);
        // Hold off new requests until every command has come back.
        wait_idle();
        queue_random(60);
        wait_idle();

        write_all(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'h7FFF, 32'h7FFF, 32'hFFFF_8000);
        queue_random(100);
        wait_idle();

        write_all(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'h7FFF);
        queue_random(60);
        wait_idle();

        write_all(0, 0, 19661, 6554, 12288, -32'sd3277);
        queue_random(140);
        wait_idle();

        repeat (3)
        begin
            write_all($urandom_range(0, 4_000_000) - 2_000_000,
                      $urandom_range(0, 4_000_000) - 2_000_000,
                      $urandom_range(0, 100000), $urandom_range(0, 32767),
                      $urandom_range(0, 32767), $urandom_range(0, 65535));
            queue_random(95);
            wait_idle();
        end

        if (command_q.size() != 0)
            n_errors++;
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
